@@ src/twrtc_pkg.sv @@
package twrtc_pkg;

  // Burst length in bytes and the counter width that follows from it.
  localparam int BURST_BYTES = 8;
  localparam int BYTE_W = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
  localparam int TIME_VALUES = 7;
  localparam int FILL_N = (BURST_BYTES < TIME_VALUES) ? BURST_BYTES : TIME_VALUES;

  // Configuration register indexes.
  localparam logic CFG_BURST_READ = 1'b0;
  localparam logic CFG_BURST_WRITE = 1'b1;

  localparam logic [7:0] BURST_READ_RESET = 8'd191;
  localparam logic [7:0] BURST_WRITE_RESET = 8'd190;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SINGLE_READ = 2'd1,
    OP_BURST_READ = 2'd2,
    OP_BURST_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD = 2'd1,
    PH_READ = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_BURST = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  // Binary to BCD for values below 100; the quotient by ten comes from a
  // multiply by 205 and a shift, which is exact in that range.
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0] tens;
    logic [7:0] rest;
    prod = 16'(v) * 16'd205;
    tens = prod[14:11];
    rest = v - (8'(tens) * 8'd10);
    return {tens, rest[3:0]};
  endfunction

  // BCD to binary on the two nibbles, with no digit check.
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

endpackage

@@ src/twrtc_if.sv @@
// Request channel: operation, command byte, time values and the sampled pin.
interface twrtc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] address;
  logic [7:0] seconds;
  logic [7:0] minutes;
  logic [7:0] hours;
  logic [7:0] day_of_month;
  logic [7:0] month_number;
  logic [7:0] weekday;
  logic [7:0] year_in_century;
  logic       data_pin_in;

  modport source (output valid, operation, address, seconds, minutes, hours,
                  day_of_month, month_number, weekday, year_in_century,
                  data_pin_in, input ready);
  modport sink (input valid, operation, address, seconds, minutes, hours,
                day_of_month, month_number, weekday, year_in_century,
                data_pin_in, output ready);
endinterface

// Result channel: line levels and read byte report after each request beat.
interface twrtc_res_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       data_pin_out;
  logic       data_drive;
  logic       byte_ready;
  logic [7:0] byte_value;
  logic [2:0] byte_number;
  logic       last_byte;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, chip_enable, serial_clock, data_pin_out,
                  data_drive, byte_ready, byte_value, byte_number, last_byte,
                  busy_res, rejected, input ready);
  modport sink (input valid, chip_enable, serial_clock, data_pin_out,
                data_drive, byte_ready, byte_value, byte_number, last_byte,
                busy_res, rejected, output ready);
endinterface

@@ src/three_wire_rtc_burst_master.sv @@
// Each result beat is registered and shown in the cycle after its request beat is taken.
// One request beat is taken per cycle; the only limit is the single
// result register, which is refilled in the same cycle it is drained.
// Reset (synchronous, active high) returns the bus to idle, clears the
// counters and restores both command registers; the write buffer is not reset.
module three_wire_rtc_burst_master (
  input  logic                     clk,
  input  logic                     rst,
  twrtc_req_if.sink                req,
  twrtc_res_if.source              res,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [7:0]               cfg_data
);
  import twrtc_pkg::*;

  // Transfer state.
  phase_t            phase, phase_next;
  kind_t             kind, kind_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [2:0]        bit_count, bit_count_next;
  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic              clock_half, clock_half_next;
  logic              load_buf;

  logic [7:0] burst_read_cmd;
  logic [7:0] burst_write_cmd;
  logic [7:0] write_buf [BURST_BYTES];

  logic       accept;
  logic       range_ok;
  logic       final_byte;
  logic [7:0] time_val [TIME_VALUES];
  logic [7:0] read_shift;
  op_t        op;

  // Result payload computed from the beat and the next state.
  logic       ce_d, sclk_d, dout_d, drive_d, bready_d, last_d, rej_d;
  logic [7:0] bvalue_d;
  logic [2:0] bnum_d;

  assign op = op_t'(req.operation);
  assign accept = req.valid && req.ready;
  assign req.ready = !res.valid || res.ready;

  assign time_val[0] = req.seconds;
  assign time_val[1] = req.minutes;
  assign time_val[2] = req.hours;
  assign time_val[3] = req.day_of_month;
  assign time_val[4] = req.month_number;
  assign time_val[5] = req.weekday;
  assign time_val[6] = req.year_in_century;

  assign range_ok = (req.seconds < 8'd60) && (req.minutes < 8'd60) &&
                    (req.hours < 8'd24) &&
                    (req.day_of_month >= 8'd1) && (req.day_of_month < 8'd32) &&
                    (req.month_number >= 8'd1) && (req.month_number < 8'd13) &&
                    (req.weekday >= 8'd1) && (req.weekday < 8'd8) &&
                    (req.year_in_century < 8'd100);

  assign final_byte = (kind == KIND_SINGLE) ||
                      (byte_count == BYTE_W'(BURST_BYTES - 1));
  assign read_shift = {req.data_pin_in, shift_reg[7:1]};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_read_cmd <= BURST_READ_RESET;
      burst_write_cmd <= BURST_WRITE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BURST_READ:  burst_read_cmd <= cfg_data;
        CFG_BURST_WRITE: burst_write_cmd <= cfg_data;
        default:         burst_read_cmd <= burst_read_cmd;
      endcase
    end
  end

  // Next-state logic: request start, half-period advance, byte sequencing.
  always_comb begin
    phase_next = phase;
    kind_next = kind;
    shift_reg_next = shift_reg;
    bit_count_next = bit_count;
    byte_count_next = byte_count;
    clock_half_next = clock_half;
    load_buf = 1'b0;
    if (op != OP_TICK) begin
      if (phase == PH_IDLE) begin
        bit_count_next = '0;
        byte_count_next = '0;
        clock_half_next = 1'b0;
        case (op)
          OP_SINGLE_READ: begin
            phase_next = PH_CMD;
            kind_next = KIND_SINGLE;
            shift_reg_next = req.address;
          end
          OP_BURST_READ: begin
            phase_next = PH_CMD;
            kind_next = KIND_BURST;
            shift_reg_next = burst_read_cmd;
          end
          OP_BURST_WRITE: begin
            if (range_ok) begin
              phase_next = PH_CMD;
              kind_next = KIND_WRITE;
              shift_reg_next = burst_write_cmd;
              load_buf = 1'b1;
            end else begin
              bit_count_next = bit_count;
              byte_count_next = byte_count;
              clock_half_next = clock_half;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (!clock_half) begin
        // Rising clock half: a read samples the pin into the top bit.
        if (phase == PH_READ) begin
          shift_reg_next = read_shift;
        end
        clock_half_next = 1'b1;
      end else begin
        // Falling clock half: unless reading, shift out the next bit; step the counters.
        clock_half_next = 1'b0;
        if (phase != PH_READ) begin
          shift_reg_next = {1'b0, shift_reg[7:1]};
        end
        bit_count_next = bit_count + 3'd1;
        if (bit_count == 3'd7) begin
          if (phase == PH_CMD) begin
            if (kind == KIND_WRITE) begin
              phase_next = PH_WRITE;
              shift_reg_next = write_buf[0];
            end else begin
              phase_next = PH_READ;
              shift_reg_next = '0;
            end
          end else if (final_byte) begin
            phase_next = PH_IDLE;
            shift_reg_next = '0;
            byte_count_next = '0;
          end else begin
            byte_count_next = BYTE_W'(byte_count + 1'b1);
            if (phase == PH_WRITE) begin
              shift_reg_next = write_buf[BYTE_W'(byte_count + 1'b1)];
            end else begin
              shift_reg_next = '0;
            end
          end
        end
      end
    end
  end

  // Output logic: line levels after the beat and the read byte report.
  always_comb begin
    ce_d = (phase_next != PH_IDLE);
    sclk_d = ce_d && clock_half_next;
    drive_d = (phase_next != PH_READ);
    dout_d = ce_d && drive_d && shift_reg_next[0];
    rej_d = (op != OP_TICK) &&
            ((phase != PH_IDLE) || ((op == OP_BURST_WRITE) && !range_ok));
    bready_d = (op == OP_TICK) && (phase == PH_READ) && !clock_half &&
               (bit_count == 3'd7);
    bvalue_d = bready_d ? from_bcd(read_shift) : '0;
    bnum_d = bready_d ? 3'(byte_count) : '0;
    last_d = bready_d && final_byte;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      kind <= KIND_NONE;
      shift_reg <= '0;
      bit_count <= '0;
      byte_count <= '0;
      clock_half <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      kind <= kind_next;
      shift_reg <= shift_reg_next;
      bit_count <= bit_count_next;
      byte_count <= byte_count_next;
      clock_half <= clock_half_next;
    end
  end

  // Write buffer: BCD time values, then zero bytes to fill the burst.
  always_ff @(posedge clk) begin
    if (accept && load_buf) begin
      for (int j = 0; j < FILL_N; j++) begin
        write_buf[j] <= to_bcd(time_val[j]);
      end
      for (int i = FILL_N; i < BURST_BYTES; i++) begin
        write_buf[i] <= '0;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.chip_enable <= ce_d;
      res.serial_clock <= sclk_d;
      res.data_pin_out <= dout_d;
      res.data_drive <= drive_d;
      res.byte_ready <= bready_d;
      res.byte_value <= bvalue_d;
      res.byte_number <= bnum_d;
      res.last_byte <= last_d;
      res.busy_res <= ce_d;
      res.rejected <= rej_d;
    end
  end

endmodule

@@ src/twrtc_checker.sv @@
module twrtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       chip_enable,
  input logic       serial_clock,
  input logic       data_drive,
  input logic       busy_res,
  input logic       byte_ready,
  input logic [7:0] byte_value,
  input logic [2:0] byte_number,
  input logic       last_byte
);

  // A result beat that is held back keeps its chip enable and clock levels.
  property p_hold;
    @(posedge clk) disable iff (rst)
      res_valid && !res_ready |=> $stable(chip_enable) && $stable(serial_clock);
  endproperty
  a_hold: assert property (p_hold) else $error("stalled result changed");

  // Busy flag and chip enable report the same transfer state.
  property p_busy;
    @(posedge clk) disable iff (rst)
      res_valid |-> (chip_enable == busy_res);
  endproperty
  a_busy: assert property (p_busy) else $error("busy and chip enable differ");

  // The clock toggles and the pin is released only inside a transfer.
  property p_lines;
    @(posedge clk) disable iff (rst)
      res_valid && (serial_clock || !data_drive) |-> chip_enable;
  endproperty
  a_lines: assert property (p_lines) else $error("bus activity with chip enable low");

  // Byte fields stay zero unless a read byte completes.
  property p_byte;
    @(posedge clk) disable iff (rst)
      res_valid && !byte_ready |->
        (byte_value == 8'd0) && (byte_number == 3'd0) && !last_byte;
  endproperty
  a_byte: assert property (p_byte) else $error("byte fields set without a byte");

  // No result is pending right after reset.
  property p_reset;
    @(posedge clk) $past(rst) |-> !res_valid;
  endproperty
  a_reset: assert property (p_reset) else $error("result valid after reset");

endmodule

bind three_wire_rtc_burst_master twrtc_checker u_twrtc_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .chip_enable(res.chip_enable),
  .serial_clock(res.serial_clock),
  .data_drive(res.data_drive),
  .busy_res(res.busy_res),
  .byte_ready(res.byte_ready),
  .byte_value(res.byte_value),
  .byte_number(res.byte_number),
  .last_byte(res.last_byte)
);
